// File: rtl/sqhp_pkg.sv
// Shared types and constants for the sorted queue with half purge.
// No dependencies; imported by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package sqhp_pkg;

   localparam int VALUE_W   = 32;
   localparam int COUNT_W   = 7;
   localparam int REMOVED_W = 6;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_PURGE  = 1'b1;

   typedef struct packed {
      logic insert;
      logic shift;
   } sqhp_ctrl_type;

endpackage

// File: rtl/sqhp_req_if.sv
// Request channel: valid/ready handshake carrying command and value.
// Depends on sqhp_pkg for field widths.
`timescale 1ns / 1ps

interface sqhp_req_if;
   import sqhp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

// File: rtl/sqhp_rsp_if.sv
// Response channel: valid/ready handshake carrying count, head value and flags.
// Depends on sqhp_pkg for field widths.
`timescale 1ns / 1ps

interface sqhp_rsp_if;
   import sqhp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [COUNT_W-1:0]        count;
   logic signed [VALUE_W-1:0] smallest;
   logic [REMOVED_W-1:0]      removed;
   logic                      was_empty;
   logic                      was_full;

   modport source (output valid, output count, output smallest, output removed,
                   output was_empty, output was_full, input ready);
   modport sink   (input valid, input count, input smallest, input removed,
                   input was_empty, input was_full, output ready);
endinterface

// File: rtl/sqhp_cell.sv
// One slot of the sorted chain: holds an entry and its valid bit.
// Depends on sqhp_pkg; instantiated once per slot by the top level.
`timescale 1ns / 1ps

module sqhp_cell
   import sqhp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  sqhp_ctrl_type             ctrl,
   input  logic signed [VALUE_W-1:0] ins_value,
   input  logic signed [VALUE_W-1:0] prev_entry,
   input  logic                      prev_valid,
   input  logic                      prev_lt,
   input  logic signed [VALUE_W-1:0] next_entry,
   input  logic                      next_valid,
   output logic signed [VALUE_W-1:0] entry,
   output logic                      valid,
   output logic                      lt
);

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic                      valid_ff, valid_in;

   assign lt = valid_ff && (entry_ff < ins_value);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctrl.insert) begin
         if (!lt) begin
            entry_in = prev_lt ? ins_value : prev_entry;
            valid_in = valid_ff | prev_valid;
         end
      end else if (ctrl.shift) begin
         entry_in = next_entry;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

// File: rtl/sorted_queue_half_purge_unit.sv
// Sorted queue with half purge: a chain of CAPACITY cells kept in ascending order.
// Insert (or refused insert, or purge of an empty queue): REPORT registers the response
// once any held one is taken. Purge: PURGE first shifts out k = max(1, count/2) entries
// at the head, one slot shift per cycle. Requests are taken only in IDLE; a held response
// stalls them. Synchronous active-high reset empties the queue; entry data is not cleared.
// Depends on sqhp_pkg, sqhp_req_if, sqhp_rsp_if and sqhp_cell.
`timescale 1ns / 1ps

module sorted_queue_half_purge_unit
   import sqhp_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input logic         clock,
   input logic         reset,
   sqhp_req_if.sink    req_ch,
   sqhp_rsp_if.source  rsp_ch
);

   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam logic [FILL_W-1:0] CAP_FILL = FILL_W'(CAPACITY);

   typedef enum logic [1:0] {IDLE, PURGE, REPORT} state_type;

   state_type                 state_ff, state_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic [FILL_W-1:0]         shift_cnt_ff, shift_cnt_in;
   logic [FILL_W-1:0]         removed_ff, removed_in;
   logic                      empty_flag_ff, empty_flag_in;
   logic                      full_flag_ff, full_flag_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic signed [VALUE_W-1:0] rsp_smallest_ff, rsp_smallest_in;
   logic [REMOVED_W-1:0]      rsp_removed_ff, rsp_removed_in;
   logic                      rsp_empty_ff, rsp_empty_in;
   logic                      rsp_full_ff, rsp_full_in;

   logic signed [VALUE_W-1:0] cell_entry [CAPACITY];
   logic                      cell_valid [CAPACITY];
   logic                      cell_lt    [CAPACITY];
   logic [CAPACITY-1:0]       valid_vec;

   sqhp_ctrl_type             ctrl;
   logic                      req_fire;
   logic                      is_full;
   logic                      is_empty;
   logic [FILL_W-1:0]         half;
   logic [FILL_W-1:0]         purge_n;
   logic [FILL_W+COUNT_W-1:0]   count_ext;
   logic [FILL_W+REMOVED_W-1:0] removed_ext;

   assign req_fire    = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == IDLE);
   assign is_full     = (fill_ff == CAP_FILL);
   assign is_empty    = (fill_ff == '0);
   assign half        = fill_ff >> 1;
   assign purge_n     = (half == '0) ? FILL_W'(1) : half;
   assign count_ext   = {{COUNT_W{1'b0}}, fill_ff};
   assign removed_ext = {{REMOVED_W{1'b0}}, removed_ff};

   assign ctrl.insert = req_fire && (req_ch.cmd == CMD_INSERT) && !is_full;
   assign ctrl.shift  = (state_ff == PURGE);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] p_entry, n_entry;
      logic                      p_valid, p_lt, n_valid;

      if (i == 0) begin : g_head
         assign p_entry = '0;
         assign p_valid = 1'b1;
         assign p_lt    = 1'b1;
      end else begin : g_body
         assign p_entry = cell_entry[i-1];
         assign p_valid = cell_valid[i-1];
         assign p_lt    = cell_lt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign n_entry = '0;
         assign n_valid = 1'b0;
      end else begin : g_link
         assign n_entry = cell_entry[i+1];
         assign n_valid = cell_valid[i+1];
      end

      sqhp_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .ins_value  (req_ch.value),
         .prev_entry (p_entry),
         .prev_valid (p_valid),
         .prev_lt    (p_lt),
         .next_entry (n_entry),
         .next_valid (n_valid),
         .entry      (cell_entry[i]),
         .valid      (cell_valid[i]),
         .lt         (cell_lt[i])
      );

      assign valid_vec[i] = cell_valid[i];
   end

   always_comb begin
      state_in        = state_ff;
      fill_in         = fill_ff;
      shift_cnt_in    = shift_cnt_ff;
      removed_in      = removed_ff;
      empty_flag_in   = empty_flag_ff;
      full_flag_in    = full_flag_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_count_in    = rsp_count_ff;
      rsp_smallest_in = rsp_smallest_ff;
      rsp_removed_in  = rsp_removed_ff;
      rsp_empty_in    = rsp_empty_ff;
      rsp_full_in     = rsp_full_ff;
      case (state_ff)
         IDLE: begin
            if (req_fire) begin
               removed_in    = '0;
               empty_flag_in = 1'b0;
               full_flag_in  = 1'b0;
               state_in      = REPORT;
               if (req_ch.cmd == CMD_INSERT) begin
                  full_flag_in = is_full;
                  if (!is_full) begin
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end else if (is_empty) begin
                  empty_flag_in = 1'b1;
               end else begin
                  removed_in   = purge_n;
                  shift_cnt_in = purge_n;
                  fill_in      = fill_ff - purge_n;
                  state_in     = PURGE;
               end
            end
         end
         PURGE: begin
            shift_cnt_in = shift_cnt_ff - FILL_W'(1);
            if (shift_cnt_ff == FILL_W'(1)) begin
               state_in = REPORT;
            end
         end
         REPORT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_count_in    = count_ext[COUNT_W-1:0];
               rsp_smallest_in = cell_valid[0] ? cell_entry[0] : '0;
               rsp_removed_in  = removed_ext[REMOVED_W-1:0];
               rsp_empty_in    = empty_flag_ff;
               rsp_full_in     = full_flag_ff;
               state_in        = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         fill_ff      <= '0;
         shift_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         shift_cnt_ff <= shift_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      removed_ff      <= removed_in;
      empty_flag_ff   <= empty_flag_in;
      full_flag_ff    <= full_flag_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_smallest_ff <= rsp_smallest_in;
      rsp_removed_ff  <= rsp_removed_in;
      rsp_empty_ff    <= rsp_empty_in;
      rsp_full_ff     <= rsp_full_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.count     = rsp_count_ff;
   assign rsp_ch.smallest  = rsp_smallest_ff;
   assign rsp_ch.removed   = rsp_removed_ff;
   assign rsp_ch.was_empty = rsp_empty_ff;
   assign rsp_ch.was_full  = rsp_full_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CAP_FILL)
      else $error("fill exceeds capacity");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff != PURGE) |-> ($countones(valid_vec) == int'(fill_ff)))
      else $error("cell valid bits disagree with fill");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert |=> (fill_ff == $past(fill_ff) + FILL_W'(1)))
      else $error("insert did not grow fill");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_count_ff == '0 && !rsp_full_ff))
      else $error("empty flag with nonzero count or full flag");

endmodule
